### rtl/lmst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment table package
// Shared types and codes for the sorted segment table and its compare unit.
// ----------------------------------------------------------------------------
package lmst_pkg;

  typedef enum logic [1:0] {
    ACT_REG  = 2'd0,
    ACT_DEL  = 2'd1,
    ACT_LOOK = 2'd2,
    ACT_OVQ  = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    STS_OK        = 3'd0,
    STS_OVERLAP   = 3'd1,
    STS_FULL      = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_EMPTY     = 3'd4
  } sts_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PREP,
    S_SHIFT,
    S_PUT
  } fsm_t;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] size;
    logic [3:0]  kind;
  } seg_entry_t;

  typedef struct packed {
    logic holds;
    logic overlap;
    logic ge_end;
    logic base_eq;
  } match_t;

endpackage

### rtl/lmst_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment compare unit
// Compares one stored segment against the current key and range end.
// ----------------------------------------------------------------------------
module lmst_match (
  input  lmst_pkg::seg_entry_t ent,
  input  logic [31:0]          key,
  input  logic [32:0]          qe,
  output lmst_pkg::match_t     m
);
  import lmst_pkg::*;

  logic [32:0] ent_end;
  logic [32:0] base33;
  logic [32:0] key33;
  logic        key_below_end;

  assign base33        = {1'b0, ent.base};
  assign key33         = {1'b0, key};
  assign ent_end       = base33 + {1'b0, ent.size};
  assign key_below_end = key33 < ent_end;

  assign m.holds   = (ent.base <= key) && key_below_end;
  assign m.overlap = key_below_end && (qe > base33);
  assign m.ge_end  = base33 >= qe;
  assign m.base_eq = ent.base == key;

endmodule

### rtl/low_memory_segment_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted segment table
// Holds non-overlapping half-open segments in base order; registers,
// deletes, looks up and checks ranges against them.
// ----------------------------------------------------------------------------
// Usage: drive the request ports and pulse start while busy is low; the
// request transfers at that edge. busy stays high until the result is
// produced. The result shows on the out_ ports for one cycle with out_valid
// high; it cannot be held off, so capture it in that cycle.
// Sequence: the request is taken, then the scan reads the stored entries in
// order through the entry memory and stops early on a hit. Register then,
// where entries must move, takes a setup step, moves each entry above the
// insert point up, and writes the new entry; delete moves each entry after
// the hit down. One request is in flight at a time; the entry memory has one
// read and one write port, which sets the one-entry-per-cycle pace.
// Reset empties the table and clears the reserved kind to zero; the entry
// memory itself is not cleared. The reserved kind is written on the cfg
// channel whenever cfg_valid is high; the user must write it only while
// no request is in flight, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module low_memory_segment_table_unit #(
  parameter int unsigned MAX_SEGS    = 16,
  parameter int unsigned TOP_ADDRESS = 1048576
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_seg_base,
  input  logic [31:0] in_seg_size,
  input  logic [3:0]  in_seg_kind,
  input  logic [31:0] in_probe_address,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic        out_answer_flag,
  output logic [31:0] out_found_base,
  output logic [31:0] out_found_size,
  output logic [3:0]  out_found_kind,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_reserved_kind_code
);
  import lmst_pkg::*;

  localparam int IDX_W = (MAX_SEGS > 1) ? $clog2(MAX_SEGS) : 1;
  localparam int CNT_W = $clog2(MAX_SEGS + 1);
  localparam logic [32:0] TOP33 = {1'b0, 32'(TOP_ADDRESS)};

  seg_entry_t mem [MAX_SEGS];
  seg_entry_t rd_data_r;
  seg_entry_t wr_data;
  logic       wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;

  fsm_t state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  act_t        act_r, act_nxt;
  logic [31:0] key_r, key_nxt;
  logic [31:0] size_r, size_nxt;
  logic [3:0]  kind_r, kind_nxt;
  logic [32:0] qe_r, qe_nxt;
  logic        below_top_r, below_top_nxt;
  logic [3:0]  reserved_r;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_status_r, out_status_nxt;
  logic        out_flag_r, out_flag_nxt;
  logic [31:0] out_base_r, out_base_nxt;
  logic [31:0] out_size_r, out_size_nxt;
  logic [3:0]  out_kind_r, out_kind_nxt;

  match_t      m;
  logic [CNT_W-1:0] idx_ext;
  logic        accept;
  logic        cur_valid;
  logic        last;
  logic        term;
  logic        term_hit;
  logic        scan_end;
  logic        table_full;
  logic [CNT_W-1:0] pos_cur;
  logic [32:0] in_end;

  lmst_match u_match (
    .ent (rd_data_r),
    .key (key_r),
    .qe  (qe_r),
    .m   (m)
  );

  assign busy      = state_r != S_IDLE;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign idx_ext    = CNT_W'(idx_r);
  assign cur_valid  = idx_ext < count_r;
  assign last       = (idx_ext + CNT_W'(1)) == count_r;
  assign table_full = count_r == CNT_W'(MAX_SEGS);
  assign in_end     = {1'b0, in_seg_base} + {1'b0, in_seg_size};

  always_comb begin
    case (act_r)
      ACT_REG:  term = m.overlap;
      ACT_DEL:  term = m.base_eq;
      ACT_LOOK: term = m.holds;
      ACT_OVQ:  term = !below_top_r || m.overlap;
      default:  term = 1'b0;
    endcase
  end

  assign term_hit = cur_valid && term;
  assign scan_end = !cur_valid || (!term && last);
  assign pos_cur  = (act_r == ACT_REG && cur_valid && pos_r == count_r && m.ge_end) ?
                    idx_ext : pos_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (term_hit) begin
          state_nxt = (act_r == ACT_DEL && !last) ? S_SHIFT : S_IDLE;
        end else if (scan_end) begin
          if (act_r == ACT_REG && !table_full) begin
            state_nxt = (pos_cur == count_r) ? S_PUT : S_PREP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_PREP: state_nxt = S_SHIFT;
      S_SHIFT: begin
        if (act_r == ACT_REG) begin
          if (idx_ext == pos_r + CNT_W'(1)) begin
            state_nxt = S_PUT;
          end
        end else if (idx_ext + CNT_W'(2) == count_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_PUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    count_nxt      = count_r;
    act_nxt        = act_r;
    key_nxt        = key_r;
    size_nxt       = size_r;
    kind_nxt       = kind_r;
    qe_nxt         = qe_r;
    below_top_nxt  = below_top_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_flag_nxt   = out_flag_r;
    out_base_nxt   = out_base_r;
    out_size_nxt   = out_size_r;
    out_kind_nxt   = out_kind_r;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = rd_data_r;
    rd_addr        = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          act_nxt       = act_t'(in_action);
          key_nxt       = (act_t'(in_action) == ACT_LOOK) ? in_probe_address : in_seg_base;
          size_nxt      = in_seg_size;
          kind_nxt      = in_seg_kind;
          qe_nxt        = (act_t'(in_action) == ACT_OVQ && in_end > TOP33) ? TOP33 : in_end;
          below_top_nxt = {1'b0, in_seg_base} < TOP33;
          idx_nxt       = '0;
          pos_nxt       = count_r;
        end
      end
      S_SCAN: begin
        rd_addr = idx_r + IDX_W'(1);
        idx_nxt = idx_r + IDX_W'(1);
        pos_nxt = pos_cur;
        if (term_hit || scan_end) begin
          out_status_nxt = STS_OK;
          out_flag_nxt   = 1'b0;
          out_base_nxt   = '0;
          out_size_nxt   = '0;
          out_kind_nxt   = '0;
        end
        if (term_hit) begin
          idx_nxt = idx_r;
          case (act_r)
            ACT_REG: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STS_OVERLAP;
            end
            ACT_DEL: begin
              if (last) begin
                out_valid_nxt = 1'b1;
                count_nxt     = count_r - CNT_W'(1);
              end
            end
            ACT_LOOK: begin
              out_valid_nxt = 1'b1;
              out_flag_nxt  = 1'b1;
              out_base_nxt  = rd_data_r.base;
              out_size_nxt  = rd_data_r.size;
              out_kind_nxt  = rd_data_r.kind;
            end
            ACT_OVQ: begin
              out_valid_nxt = 1'b1;
              out_flag_nxt  = below_top_r;
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end else if (scan_end) begin
          case (act_r)
            ACT_REG: begin
              if (table_full) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STS_FULL;
              end
            end
            ACT_DEL: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = (count_r == '0) ? STS_EMPTY : STS_NOT_FOUND;
            end
            ACT_LOOK: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STS_NOT_FOUND;
              out_kind_nxt   = reserved_r;
            end
            default: out_valid_nxt = 1'b1;
          endcase
        end
      end
      S_PREP: begin
        idx_nxt = IDX_W'(count_r);
        rd_addr = IDX_W'(count_r - CNT_W'(1));
      end
      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = rd_data_r;
        if (act_r == ACT_REG) begin
          rd_addr = idx_r - IDX_W'(2);
          idx_nxt = idx_r - IDX_W'(1);
        end else begin
          rd_addr = idx_r + IDX_W'(2);
          idx_nxt = idx_r + IDX_W'(1);
          if (idx_ext + CNT_W'(2) == count_r) begin
            out_valid_nxt = 1'b1;
            count_nxt     = count_r - CNT_W'(1);
          end
        end
      end
      S_PUT: begin
        wr_en          = 1'b1;
        wr_addr        = IDX_W'(pos_r);
        wr_data.base   = key_r;
        wr_data.size   = size_r;
        wr_data.kind   = kind_r;
        count_nxt      = count_r + CNT_W'(1);
        out_valid_nxt  = 1'b1;
        out_status_nxt = STS_OK;
        out_flag_nxt   = 1'b0;
        out_base_nxt   = '0;
        out_size_nxt   = '0;
        out_kind_nxt   = '0;
      end
      default: begin
        idx_nxt = idx_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      reserved_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        reserved_r <= cfg_reserved_kind_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    act_r        <= act_nxt;
    key_r        <= key_nxt;
    size_r       <= size_nxt;
    kind_r       <= kind_nxt;
    qe_r         <= qe_nxt;
    below_top_r  <= below_top_nxt;
    out_status_r <= out_status_nxt;
    out_flag_r   <= out_flag_nxt;
    out_base_r   <= out_base_nxt;
    out_size_r   <= out_size_nxt;
    out_kind_r   <= out_kind_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_answer_flag = out_flag_r;
  assign out_found_base  = out_base_r;
  assign out_found_size  = out_size_r;
  assign out_found_kind  = out_kind_r;

endmodule
